[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LMTBS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a non-overlapping implication outside reset.
`define LMTBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lmtbs_pkg.sv]
`default_nettype none
package lmtbs_pkg;

	localparam logic [1:0] OP_SCAN   = 2'd0;
	localparam logic [1:0] OP_BEGIN  = 2'd1;
	localparam logic [1:0] OP_SPRITE = 2'd2;

	localparam int BUFFERS     = 3;
	localparam int SPRITE_COLS = 8;

	localparam logic [1:0] BUF_SHOWN   = 2'd0;
	localparam logic [1:0] BUF_WAITING = 2'd1;
	localparam logic [1:0] BUF_COMPOSE = 2'd2;
	localparam logic [1:0] BUF_INVALID = 2'd3;

	localparam logic [7:0] COL_SEL_BASE = 8'h80;

	typedef logic [7:0] row_t;
	typedef logic [1:0] buf_id_t;

	typedef struct packed {
		logic scan;
		logic begin_frame;
		logic add_sprite;
	} cmd_t;

	typedef struct packed {
		row_t       row;
		logic [2:0] column;
		logic       swapped;
	} scan_t;

	function automatic buf_id_t buf_index(buf_id_t b);
		return (b == BUF_INVALID) ? BUF_SHOWN : b;
	endfunction

endpackage
`default_nettype wire

[sv/lmtbs_lane.sv]
`default_nettype none
module lmtbs_lane
	import lmtbs_pkg::*;
#(
	parameter int LANE = 0
) (
	input  wire logic signed [7:0] pos_x,
	input  wire logic signed [7:0] pos_y,
	input  wire row_t              sprite [SPRITE_COLS],
	output row_t                   bits
);

	logic signed [9:0] src;
	logic              hit;
	logic              too_far;
	logic [7:0]        neg;
	row_t              sel;

	// source sprite column that lands on this lane
	assign src     = $signed(10'(LANE)) - 10'(pos_x);
	assign hit     = (src[9:3] == 7'd0);
	assign sel     = sprite[src[2:0]];
	assign too_far = (!pos_y[7] && (pos_y[6:3] != 4'd0)) || (pos_y < -8'sd7);
	assign neg     = 8'(-pos_y);

	always_comb begin
		if (!hit || too_far) begin
			bits = '0;
		end else if (!pos_y[7]) begin
			bits = sel << pos_y[2:0];
		end else begin
			bits = sel >> neg[2:0];
		end
	end

endmodule
`default_nettype wire

[sv/lmtbs_store.sv]
`default_nettype none
module lmtbs_store
	import lmtbs_pkg::*;
#(
	parameter int MATRIX_SIZE = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire row_t lane_rows [MATRIX_SIZE],
	output scan_t     scan
);

	localparam int CW = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
	localparam logic [CW-1:0] LAST_COL = CW'(MATRIX_SIZE - 1);

	row_t          frame_q [BUFFERS][MATRIX_SIZE];
	buf_id_t       shown_q;
	buf_id_t       waiting_q;
	buf_id_t       compose_q;
	logic [CW-1:0] col_q;
	logic          pending_q;

	logic    take;
	buf_id_t rd_buf;
	buf_id_t cb;

	assign take   = (col_q == '0) && pending_q;
	assign rd_buf = buf_index(take ? waiting_q : shown_q);
	assign cb     = buf_index(compose_q);

	assign scan.row     = frame_q[rd_buf][col_q];
	assign scan.column  = 3'(col_q);
	assign scan.swapped = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q   <= BUF_SHOWN;
			waiting_q <= BUF_WAITING;
			compose_q <= BUF_COMPOSE;
			col_q     <= '0;
			pending_q <= 1'b0;
		end else begin
			if (cmd.scan) begin
				if (take) begin
					shown_q   <= waiting_q;
					waiting_q <= shown_q;
					pending_q <= 1'b0;
				end
				col_q <= (col_q == LAST_COL) ? '0 : col_q + 1'b1;
			end
			if (cmd.begin_frame) begin
				waiting_q <= compose_q;
				compose_q <= waiting_q;
				pending_q <= 1'b1;
			end
		end
	end

	// merge lane results into the composing buffer, or clear the waiting buffer as it becomes composing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUFFERS; b++) begin
				for (int c = 0; c < MATRIX_SIZE; c++) begin
					frame_q[b][c] <= '0;
				end
			end
		end else begin
			for (int b = 0; b < BUFFERS; b++) begin
				for (int c = 0; c < MATRIX_SIZE; c++) begin
					if (cmd.begin_frame && (buf_id_t'(b) == buf_index(waiting_q))) begin
						frame_q[b][c] <= '0;
					end else if (cmd.add_sprite && (buf_id_t'(b) == cb)) begin
						frame_q[b][c] <= frame_q[b][c] | lane_rows[c];
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

[sv/led_matrix_triple_buffer_scanner.sv]
// Channel  Dir  tdata fields (low bit up)
// s_axis   in   operation[1:0] pos_x[9:2] pos_y[17:10] sprite_col_0..7[81:18], pad to 88
// m_axis   out  column_word[15:0] column_number[18:16] frame_swapped[19], pad to 24
//
// One beat a cycle: each input beat is applied to the frame store at the edge it is taken.
// Sprite placement runs in MATRIX_SIZE column lanes in parallel within that cycle.
// A scan beat's column beat comes from the output register in the cycle after it is taken.
// The input stalls only while that register is full and m_tready is low.
// Reset clears the frame store and buffer roles at once; no clearing pass.
`default_nettype none
module led_matrix_triple_buffer_scanner
	import lmtbs_pkg::*;
#(
	parameter int MATRIX_SIZE = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,  // operation, pos_x, pos_y, sprite_col_0..7
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata   // column_word, column_number, frame_swapped
);

	logic              accept;
	logic [1:0]        operation;
	logic signed [7:0] pos_x;
	logic signed [7:0] pos_y;
	row_t              sprite    [SPRITE_COLS];
	row_t              lane_rows [MATRIX_SIZE];
	cmd_t              cmd;
	scan_t             scan;

	logic              out_valid_q;
	logic [15:0]       word_q;
	logic [2:0]        column_q;
	logic              swapped_q;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign operation = s_tdata[1:0];
	assign pos_x     = s_tdata[9:2];
	assign pos_y     = s_tdata[17:10];

	always_comb begin
		for (int k = 0; k < SPRITE_COLS; k++) begin
			sprite[k] = s_tdata[18 + 8*k +: 8];
		end
	end

	assign cmd.scan        = accept && (operation == OP_SCAN);
	assign cmd.begin_frame = accept && (operation == OP_BEGIN);
	assign cmd.add_sprite  = accept && (operation == OP_SPRITE);

	for (genvar c = 0; c < MATRIX_SIZE; c++) begin : g_lane
		lmtbs_lane #(
			.LANE(c)
		) u_lane (
			.pos_x (pos_x),
			.pos_y (pos_y),
			.sprite(sprite),
			.bits  (lane_rows[c])
		);
	end

	lmtbs_store #(
		.MATRIX_SIZE(MATRIX_SIZE)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.lane_rows(lane_rows),
		.scan     (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.scan) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			word_q    <= {scan.row, COL_SEL_BASE >> scan.column};
			column_q  <= scan.column;
			swapped_q <= scan.swapped;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, swapped_q, column_q, word_q};

endmodule
`default_nettype wire

[sv/lmtbs_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module lmtbs_checker #(
	parameter int MATRIX_SIZE = 8
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	`LMTBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "output beat changed while stalled")
	`LMTBS_ASSERT_IMPL(a_backpressure, m_tvalid && !m_tready, !s_tready,
		"input taken while output stalled")
	`LMTBS_ASSERT_IMPL(a_col_select, m_tvalid,
		$onehot(m_tdata[7:0]) && (m_tdata[7:0] == (8'h80 >> m_tdata[18:16])),
		"column select does not match column")
	`LMTBS_ASSERT_IMPL(a_swap_col0, m_tvalid && m_tdata[19], m_tdata[18:16] == 3'd0,
		"frame taken away from column zero")
	`LMTBS_ASSERT_IMPL(a_col_range, m_tvalid,
		{1'b0, m_tdata[18:16]} < 4'(MATRIX_SIZE), "column beyond matrix")

endmodule

bind led_matrix_triple_buffer_scanner lmtbs_checker #(
	.MATRIX_SIZE(MATRIX_SIZE)
) u_lmtbs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
